### rtl/mprs_pkg.sv
// mprs_pkg: shared constants and controller/datapath command types for the scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mprs_pkg;
  localparam int MAX_TASKS_DEF  = 32;
  localparam int NUM_LEVELS_DEF = 32;
  localparam int ID_W   = 5;
  localparam int TIME_W = 16;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic capture;    // latch request fields
    logic arr_write;  // perform arrival
    logic rot_read;   // read rotation level head/tail/link
    logic rot_write;  // commit rotation
    logic srv_read;   // read served head state
    logic srv_write;  // commit serve, emit result
  } cmd_t;

  typedef struct packed {
    logic is_tick;
  } stat_t;
endpackage
`default_nettype wire

### rtl/multilevel_priority_rr_scheduler_top.sv
// multilevel_priority_rr_scheduler_top: multilevel FIFO/round-robin task scheduler.
// Depends on mprs_pkg, mprs_ctrl, mprs_dp, mprs_ram.
//
// Usage:
//  - A request is taken when start is high and busy is low. in_opcode selects an
//    arrival (0) or a tick (1); arrival fields give slot, level, run time, RR flag.
//  - An arrival gives no result.
//  - A tick gives one result on out_idle/out_served_task, marked by out_valid for
//    one cycle, after a rotation step (read, write) and a head read and
//    decrement step (read, write) on the link and time RAMs.
//  - A new request is taken only once the previous one is done and busy is low.
//  - Results cannot be held off; out_valid is a single-cycle strobe.
//  - Reset (rst_n low, synchronous) empties every level and clears any pending
//    rotation; task memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_priority_rr_scheduler_top #(
  parameter int MAX_TASKS  = mprs_pkg::MAX_TASKS_DEF,
  parameter int NUM_LEVELS = mprs_pkg::NUM_LEVELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_opcode,
  input  wire logic [mprs_pkg::ID_W-1:0]   in_task_id,
  input  wire logic [mprs_pkg::ID_W-1:0]   in_priority_level,
  input  wire logic [mprs_pkg::TIME_W-1:0] in_run_time,
  input  wire logic                        in_round_robin,
  output logic                             out_valid,
  output logic                             out_idle,
  output logic [mprs_pkg::ID_W-1:0]        out_served_task
);
  mprs_pkg::cmd_t  cmd;
  mprs_pkg::stat_t stat;

  mprs_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .stat(stat),
                    .busy(busy), .cmd(cmd));

  mprs_dp #(.MAX_TASKS(MAX_TASKS), .NUM_LEVELS(NUM_LEVELS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_opcode(in_opcode), .in_task_id(in_task_id),
    .in_priority_level(in_priority_level), .in_run_time(in_run_time),
    .in_round_robin(in_round_robin), .out_valid(out_valid),
    .out_idle(out_idle), .out_served_task(out_served_task));
endmodule
`default_nettype wire

### rtl/mprs_ram.sv
// mprs_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mprs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/mprs_ctrl.sv
// mprs_ctrl: sequencer for arrival and tick requests.
// Depends on mprs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mprs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  mprs_pkg::stat_t     stat,
  output logic                busy,
  output mprs_pkg::cmd_t      cmd
);
  typedef enum logic [2:0] {S_IDLE, S_DEC, S_ARR, S_RRD, S_RWR, S_SRD, S_SWR} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_DEC;
      S_DEC:   state_nxt = stat.is_tick ? S_RRD : S_ARR;
      S_ARR:   state_nxt = S_IDLE;
      S_RRD:   state_nxt = S_RWR;
      S_RWR:   state_nxt = S_SRD;
      S_SRD:   state_nxt = S_SWR;
      S_SWR:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    busy = (state_r != S_IDLE);
    cmd = '0;
    cmd.capture   = (state_r == S_IDLE) && start;
    cmd.arr_write = (state_r == S_ARR);
    cmd.rot_read  = (state_r == S_RRD);
    cmd.rot_write = (state_r == S_RWR);
    cmd.srv_read  = (state_r == S_SRD);
    cmd.srv_write = (state_r == S_SWR);
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("multiple commands");
  a_srv: assert property (@(posedge clk) disable iff (!rst_n) cmd.srv_read |=> cmd.srv_write)
    else $error("serve split");
  a_rot: assert property (@(posedge clk) disable iff (!rst_n) cmd.rot_write |=> cmd.srv_read)
    else $error("rotation not followed by serve");
endmodule
`default_nettype wire

### rtl/mprs_dp.sv
// mprs_dp: queue state, link memories and serve logic for the scheduler.
// Depends on mprs_pkg and mprs_ram.
`timescale 1ns / 1ps
`default_nettype none
module mprs_dp #(
  parameter int MAX_TASKS  = mprs_pkg::MAX_TASKS_DEF,
  parameter int NUM_LEVELS = mprs_pkg::NUM_LEVELS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  mprs_pkg::cmd_t                  cmd,
  output mprs_pkg::stat_t                 stat,
  input  wire logic                       in_opcode,
  input  wire logic [mprs_pkg::ID_W-1:0]  in_task_id,
  input  wire logic [mprs_pkg::ID_W-1:0]  in_priority_level,
  input  wire logic [mprs_pkg::TIME_W-1:0] in_run_time,
  input  wire logic                       in_round_robin,
  output logic                            out_valid,
  output logic                            out_idle,
  output logic [mprs_pkg::ID_W-1:0]       out_served_task
);
  localparam int SW = $clog2(MAX_TASKS);
  localparam int LW = $clog2(NUM_LEVELS);
  localparam int TW = mprs_pkg::TIME_W;

  logic          op_r, rr_r;
  logic [SW-1:0] slot_r;
  logic [LW-1:0] lvl_r;
  logic [TW-1:0] rt_r;

  // level head/tail as registers: read at arbitrary levels, small
  logic [SW-1:0] head_r [NUM_LEVELS];
  logic [SW-1:0] tail_r [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] nonempty_r;
  logic [MAX_TASKS-1:0]  queued_r;
  logic          rot_pend_r;
  logic [LW-1:0] rot_lvl_r;

  // memories
  logic          nx_we;  logic [SW-1:0] nx_wa, nx_wd, nx_ra, nx_rd;
  logic          tm_we;  logic [SW-1:0] tm_wa, tm_ra; logic [TW:0] tm_wd, tm_rd;

  mprs_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  mprs_ram #(.WIDTH(TW+1), .DEPTH(MAX_TASKS)) u_time (
    .clk(clk), .we(tm_we), .waddr(tm_wa), .wdata(tm_wd), .raddr(tm_ra), .rdata(tm_rd));

  // priority pick over nonempty levels
  logic          any_ne;
  logic [LW-1:0] pick;
  always_comb begin
    any_ne = |nonempty_r;
    pick = '0;
    for (int i = NUM_LEVELS-1; i >= 0; i--)
      if (nonempty_r[i]) pick = LW'(i);
  end
  logic          srv_any_r;
  logic [LW-1:0] srv_lvl_r;
  logic [SW-1:0] srv_slot_r;

  logic          rot_do;
  assign rot_do = rot_pend_r && nonempty_r[rot_lvl_r] && (head_r[rot_lvl_r] != tail_r[rot_lvl_r]);

  assign stat.is_tick = op_r;

  logic [TW-1:0] dec;
  assign dec = tm_rd[TW-1:0] - TW'(1);

  always_comb begin
    nx_we = 1'b0; nx_wa = tail_r[lvl_r]; nx_wd = slot_r;
    nx_ra = head_r[rot_lvl_r];
    tm_we = 1'b0; tm_wa = slot_r;
    tm_wd = {rr_r, (rt_r == '0) ? TW'(1) : rt_r};
    tm_ra = head_r[pick];
    if (cmd.arr_write) begin
      nx_we = nonempty_r[lvl_r] && !queued_r[slot_r];
      tm_we = !queued_r[slot_r];
    end else if (cmd.rot_write) begin
      // old head appended after tail
      nx_we = rot_do;
      nx_wa = tail_r[rot_lvl_r];
      nx_wd = head_r[rot_lvl_r];
    end else if (cmd.srv_write) begin
      tm_we = srv_any_r;
      tm_wa = srv_slot_r;
      tm_wd = {tm_rd[TW], dec};
    end
    if (cmd.srv_read) nx_ra = head_r[pick];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_opcode; rr_r <= in_round_robin; rt_r <= in_run_time;
      slot_r <= SW'(in_task_id); lvl_r <= LW'(in_priority_level);
    end
    if (cmd.srv_read) begin
      srv_any_r <= any_ne; srv_lvl_r <= pick; srv_slot_r <= head_r[pick];
    end
    if (cmd.arr_write && !queued_r[slot_r]) begin
      if (!nonempty_r[lvl_r]) head_r[lvl_r] <= slot_r;
      tail_r[lvl_r] <= slot_r;
    end
    if (cmd.rot_write && rot_do) begin
      head_r[rot_lvl_r] <= nx_rd;
      tail_r[rot_lvl_r] <= head_r[rot_lvl_r];
    end
    if (cmd.srv_write && srv_any_r && dec == '0 && tail_r[srv_lvl_r] != srv_slot_r)
      head_r[srv_lvl_r] <= nx_rd;
  end

  // serve: time and link of the picked head are read in srv_read, so the
  // registered data is there for srv_write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r <= '0; queued_r <= '0; rot_pend_r <= 1'b0; rot_lvl_r <= '0;
      out_valid <= 1'b0; out_idle <= 1'b0; out_served_task <= '0;
    end else begin
      out_valid <= 1'b0;
      if (cmd.arr_write && !queued_r[slot_r]) begin
        nonempty_r[lvl_r] <= 1'b1; queued_r[slot_r] <= 1'b1;
      end
      if (cmd.rot_write) rot_pend_r <= 1'b0;
      if (cmd.srv_write) begin
        out_valid <= 1'b1;
        out_idle <= !srv_any_r;
        out_served_task <= srv_any_r ? mprs_pkg::ID_W'(srv_slot_r) : '0;
        if (srv_any_r) begin
          if (dec == '0) begin
            queued_r[srv_slot_r] <= 1'b0;
            if (tail_r[srv_lvl_r] == srv_slot_r) nonempty_r[srv_lvl_r] <= 1'b0;
          end else if (tm_rd[TW]) begin
            rot_pend_r <= 1'b1; rot_lvl_r <= srv_lvl_r;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire
